[rtl/websocket_frame_deframer_macros.svh]
// assertion macros shared by the deframer rtl
// expects i_clk and i_rst_n in the including module
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// property must hold at every clock outside reset
`define WSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition must never be true outside reset
`define WSD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

[rtl/wsd_pkg.sv]
// types and constants of the websocket frame deframer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT16,
        PH_EXT64,
        PH_MASK,
        PH_PAYLOAD
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_RSV,
        ERR_LEN_MSB,
        ERR_MASKED,
        ERR_CONTROL,
        ERR_ORPHAN,
        ERR_UNKNOWN,
        ERR_MID_FRAG
    } t_err;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [7:0] RSV_BITS     = 8'h70;
    localparam logic [6:0] LEN7_EXT16   = 7'd126;
    localparam logic [62:0] CTRL_MAX_LEN = 63'd125;

    localparam int LEN_W = 63;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic [3:0] msg_opcode;
        logic       last;
        t_err       err_code;
    } t_result;

endpackage

`default_nettype wire

[rtl/websocket_frame_deframer.sv]
// Receive-side WebSocket deframer for a server-to-client byte stream. Takes one
// word (stream byte) per cycle when not stalled; at most one result per word.
// A result is written into a P_FIFO_DEPTH entry queue when its word is accepted,
// and the output stage loads it from there into the output register.
// Header parse, checks and fragment tracking run in the parser at one word
// per cycle unless stalled, bounded by the 63-bit remaining-length decrement.
// When the output is stalled the queue fills and o_stall rises once it is full.
// After the first protocol error one error result is given and all words are
// dropped until reset.
// top level; depends on wsd_pkg, wsd_front, wsd_fifo, wsd_back
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer #(
    parameter int P_FIFO_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_data_byte,
    output logic            o_stall,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_payload_byte,
    output logic            o_byte_valid,
    output logic [3:0]      o_msg_opcode,
    output logic            o_last,
    output logic [2:0]      o_err_code
);
    import wsd_pkg::*;

    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_result wr_rec;
    t_result rd_rec;
    t_result out_rec;

    assign o_stall = full;

    wsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_full      (full),
        .o_push      (push),
        .o_rec       (wr_rec)
    );

    wsd_fifo #(
        .DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (wr_rec),
        .i_pop   (pop),
        .o_rdata (rd_rec),
        .o_full  (full),
        .o_empty (empty)
    );

    wsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_rdata (rd_rec),
        .o_pop   (pop),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_rec   (out_rec)
    );

    assign o_payload_byte = out_rec.payload_byte;
    assign o_byte_valid   = out_rec.byte_valid;
    assign o_msg_opcode   = out_rec.msg_opcode;
    assign o_last         = out_rec.last;
    assign o_err_code     = out_rec.err_code;

endmodule

`default_nettype wire

[rtl/wsd_fifo.sv]
// short result queue between the frame parser and the output stage
// depends on wsd_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_deframer_macros.svh"

module wsd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire wsd_pkg::t_result i_wdata,
    input  wire logic             i_pop,
    output wsd_pkg::t_result      o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);
    import wsd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_result       r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    `WSD_ASSERT(a_no_push_full, i_push |-> !o_full, "push into full result queue")
    `WSD_ASSERT(a_no_pop_empty, i_pop |-> !o_empty, "pop from empty result queue")

endmodule

`default_nettype wire

[rtl/wsd_front.sv]
// frame parser: header decode, checks, fragmentation tracking, result build
// depends on wsd_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_deframer_macros.svh"

module wsd_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_full,
    output logic              o_push,
    output wsd_pkg::t_result  o_rec
);
    import wsd_pkg::*;

    t_phase           r_phase,    n_phase;
    logic [3:0]       r_hdr_cnt,  n_hdr_cnt;
    logic             r_fin,      n_fin;
    logic [3:0]       r_op,       n_op;
    logic             r_masked,   n_masked;
    logic [LEN_W-1:0] r_rem,      n_rem;
    logic [55:0]      r_len_sh,   n_len_sh;
    logic [3:0]       r_msg_op,   n_msg_op;
    logic             r_frag,     n_frag;
    logic             r_failed,   n_failed;

    logic             take;
    logic [6:0]       len7;
    logic [3:0]       cnt_dec;
    logic [63:0]      len_cat;
    logic             ext_done;
    logic             len_known;
    logic             len_masked;
    logic [LEN_W-1:0] known_len;
    logic             len_zero;
    logic             fh;
    logic             is_ctrl;
    logic             start_msg;
    logic [3:0]       msg_op;
    logic             pl_end;
    t_err             fh_err;
    t_err             err_now;

    assign take = i_valid && !i_full && !r_failed;

    // decode of the current word against the parser state
    always_comb begin
        len7     = i_data_byte[6:0];
        cnt_dec  = r_hdr_cnt - 4'd1;
        len_cat  = {r_len_sh, i_data_byte};
        ext_done = (r_phase == PH_EXT16 || r_phase == PH_EXT64) && (cnt_dec == 4'd0);
        len_known = (r_phase == PH_HDR1 && len7 < LEN7_EXT16)
                 || (ext_done && !(r_phase == PH_EXT64 && len_cat[63]));
        len_masked = (r_phase == PH_HDR1) ? i_data_byte[7] : r_masked;
        known_len  = (r_phase == PH_HDR1) ? {56'd0, len7} : len_cat[LEN_W-1:0];
        len_zero   = (known_len == '0);
        fh         = len_known && !len_masked;
        is_ctrl    = (r_op == OP_CLOSE) || (r_op == OP_PING) || (r_op == OP_PONG);
        start_msg  = !is_ctrl && !r_frag;
        msg_op     = start_msg ? r_op : r_msg_op;
        pl_end     = (r_rem == LEN_W'(1));

        if (is_ctrl) begin
            fh_err = (!r_fin || known_len > CTRL_MAX_LEN) ? ERR_CONTROL : ERR_NONE;
        end else if (!r_frag) begin
            if (r_op == OP_CONT) begin
                fh_err = ERR_ORPHAN;
            end else if (r_op != OP_TEXT && r_op != OP_BINARY) begin
                fh_err = ERR_UNKNOWN;
            end else begin
                fh_err = ERR_NONE;
            end
        end else begin
            fh_err = (r_op != OP_CONT) ? ERR_MID_FRAG : ERR_NONE;
        end

        unique case (r_phase)
            PH_HDR0:  err_now = ((i_data_byte & RSV_BITS) != '0) ? ERR_RSV : ERR_NONE;
            PH_HDR1:  err_now = fh ? fh_err : ERR_NONE;
            PH_EXT16: err_now = fh ? fh_err : ERR_NONE;
            PH_EXT64: begin
                if (ext_done && len_cat[63]) begin
                    err_now = ERR_LEN_MSB;
                end else begin
                    err_now = fh ? fh_err : ERR_NONE;
                end
            end
            PH_MASK:  err_now = (cnt_dec == 4'd0) ? ERR_MASKED : ERR_NONE;
            default:  err_now = ERR_NONE;
        endcase
    end

    // next state
    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_fin     = r_fin;
        n_op      = r_op;
        n_masked  = r_masked;
        n_rem     = r_rem;
        n_len_sh  = r_len_sh;
        n_msg_op  = r_msg_op;
        n_frag    = r_frag;
        n_failed  = r_failed;
        if (take) begin
            if (err_now != ERR_NONE) begin
                n_failed = 1'b1;
                n_phase  = PH_HDR0;
            end else begin
                unique case (r_phase)
                    PH_HDR0: begin
                        n_fin   = i_data_byte[7];
                        n_op    = i_data_byte[3:0];
                        n_phase = PH_HDR1;
                    end
                    PH_HDR1: begin
                        n_masked = i_data_byte[7];
                        n_len_sh = '0;
                        if (!len_known) begin
                            n_phase   = (len7 == LEN7_EXT16) ? PH_EXT16 : PH_EXT64;
                            n_hdr_cnt = (len7 == LEN7_EXT16) ? 4'd2 : 4'd8;
                        end
                    end
                    PH_EXT16, PH_EXT64: begin
                        n_len_sh  = len_cat[55:0];
                        n_hdr_cnt = cnt_dec;
                    end
                    PH_MASK: begin
                        n_hdr_cnt = cnt_dec;
                    end
                    PH_PAYLOAD: begin
                        n_rem = r_rem - LEN_W'(1);
                        if (pl_end) begin
                            n_phase = PH_HDR0;
                            if (!is_ctrl && r_fin) begin
                                n_frag = 1'b0;
                            end
                        end
                    end
                    default: n_phase = PH_HDR0;
                endcase

                // header complete
                if (len_known) begin
                    n_rem = known_len;
                    if (len_masked) begin
                        n_phase   = PH_MASK;
                        n_hdr_cnt = 4'd4;
                    end else begin
                        n_phase = len_zero ? PH_HDR0 : PH_PAYLOAD;
                        if (is_ctrl) begin
                            if (r_op == OP_CLOSE) begin
                                n_frag = 1'b0;
                            end
                        end else begin
                            if (start_msg) begin
                                n_msg_op = r_op;
                                n_frag   = 1'b1;
                            end
                            if (len_zero && r_fin) begin
                                n_frag = 1'b0;
                            end
                        end
                    end
                end
            end
        end
    end

    // result word toward the queue
    always_comb begin
        o_push = 1'b0;
        o_rec  = '{payload_byte: 8'd0, byte_valid: 1'b0, msg_opcode: 4'd0,
                   last: 1'b0, err_code: ERR_NONE};
        if (take) begin
            if (err_now != ERR_NONE) begin
                o_push         = 1'b1;
                o_rec.err_code = err_now;
            end else if (fh && len_zero) begin
                if (!is_ctrl && r_fin) begin
                    o_push           = 1'b1;
                    o_rec.msg_opcode = msg_op;
                    o_rec.last       = 1'b1;
                end else if (is_ctrl && r_op != OP_PONG) begin
                    o_push           = 1'b1;
                    o_rec.msg_opcode = r_op;
                    o_rec.last       = 1'b1;
                end
            end else if (r_phase == PH_PAYLOAD && r_op != OP_PONG) begin
                o_push             = 1'b1;
                o_rec.payload_byte = i_data_byte;
                o_rec.byte_valid   = 1'b1;
                o_rec.msg_opcode   = is_ctrl ? r_op : r_msg_op;
                o_rec.last         = is_ctrl ? pl_end : (pl_end && r_fin);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR0;
            r_hdr_cnt <= '0;
            r_fin     <= 1'b0;
            r_op      <= OP_CONT;
            r_masked  <= 1'b0;
            r_rem     <= '0;
            r_len_sh  <= '0;
            r_msg_op  <= OP_CONT;
            r_frag    <= 1'b0;
            r_failed  <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_fin     <= n_fin;
            r_op      <= n_op;
            r_masked  <= n_masked;
            r_rem     <= n_rem;
            r_len_sh  <= n_len_sh;
            r_msg_op  <= n_msg_op;
            r_frag    <= n_frag;
            r_failed  <= n_failed;
        end
    end

    `WSD_ASSERT(a_fail_sticky, r_failed |=> r_failed, "error state left without reset")
    `WSD_ASSERT(a_err_sets_fail, (o_push && o_rec.err_code != ERR_NONE) |=> r_failed,
                "error reported but parser not halted")
    `WSD_ASSERT(a_quiet_after_fail, r_failed |-> !o_push, "result produced after error")
    `WSD_ASSERT_NEVER(a_payload_len, r_phase == PH_PAYLOAD && r_rem == '0,
                      "payload phase with zero remaining length")

endmodule

`default_nettype wire

[rtl/wsd_back.sv]
// output stage: drains the result queue into the registered output port
// depends on wsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsd_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire wsd_pkg::t_result i_rdata,
    output logic                  o_pop,
    input  wire logic             i_stall,
    output logic                  o_valid,
    output wsd_pkg::t_result      o_rec
);
    import wsd_pkg::*;

    logic    r_valid;
    t_result r_rec;
    logic    load_en;

    // output register is free when empty or being taken this cycle
    assign load_en = !r_valid || !i_stall;
    assign o_pop   = load_en && !i_empty;
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load_en) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rdata;
        end
    end

endmodule

`default_nettype wire
